// ===== sv/dq_pkg.sv =====
// Package: shared types and constants of the double-ended queue.
`default_nettype none
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int COUNT_W    = 5;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [COUNT_W-1:0]    count_t;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_BACK,
        CELL_SHIFT_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_BACK
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        data_t     data;
    } cell_ctl_t;

    typedef struct packed {
        logic  valid;
        data_t data;
    } cell_link_t;

    typedef struct packed {
        kind_t         kind;
        logic [31:0]   push_value;
    } req_payload_t;

    typedef struct packed {
        logic [31:0] popped_value;
        status_t     status;
        logic [31:0] front_value;
        logic [31:0] back_value;
        count_t      entry_count;
    } rsp_payload_t;

endpackage
`default_nettype wire

// ===== sv/dq_if.sv =====
// Interfaces: request and response channels of the double-ended queue.
`default_nettype none
interface dq_req_if
    import dq_pkg::*;
;
    logic         valid;
    logic         ready;
    req_payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dq_rsp_if
    import dq_pkg::*;
;
    logic         valid;
    logic         ready;
    rsp_payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/dq_cell.sv =====
// One storage cell of the queue chain: holds an entry and trades it with its neighbors.
`default_nettype none
module dq_cell
    import dq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctl_t  ctl,
    input  wire cell_link_t left,
    input  wire cell_link_t right,
    output cell_link_t      state,
    output logic            is_back
);

    logic  valid_reg;
    logic  valid_next;
    data_t data_reg;
    data_t data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (ctl.cmd)
            CELL_HOLD:
            begin
            end
            CELL_SHIFT_BACK:
            begin
                valid_next = left.valid;
                data_next  = left.data;
            end
            CELL_SHIFT_FRONT:
            begin
                valid_next = right.valid;
                data_next  = right.data;
            end
            CELL_PUSH_BACK:
            begin
                // load only the first empty cell
                if (!valid_reg && left.valid)
                begin
                    valid_next = 1'b1;
                    data_next  = ctl.data;
                end
            end
            CELL_POP_BACK:
            begin
                if (valid_reg && !right.valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign state.valid = valid_reg;
    assign state.data  = data_reg;
    assign is_back     = valid_reg && !right.valid;

endmodule
`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// Top level: bounded double-ended queue built as a chain of storage cells.
// Throughput: one operation per cycle while responses are taken; the cell chain and
//   pending stage update in the transfer cycle, and the response register loads from
//   the pending stage when it is free or being drained.
// Reset: rst_n clears all cell valid bits, the entry count and the pending and response
//   valid flags, so the queue starts empty; stored data and payloads need no reset.
`default_nettype none
module double_ended_queue
    import dq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dq_req_if.sink    req,
    dq_rsp_if.source  rsp
);

    // Cell chain and its neighbor links. Cell 0 is the front.
    cell_ctl_t  ctl;
    cell_link_t cell_state [DEPTH];
    logic       cell_back  [DEPTH];

    // Entry count
    count_t cnt_reg;
    count_t cnt_next;

    // Pending stage: operation applied, response not yet captured
    logic        pend_reg;
    logic        pend_next;
    data_t       pend_popped_reg;
    data_t       pend_popped_next;
    status_t     pend_status_reg;
    status_t     pend_status_next;

    // Response register
    logic         out_valid_reg;
    logic         out_valid_next;
    rsp_payload_t out_reg;

    logic    accept;
    logic    advance;
    logic    full;
    logic    empty;
    kind_t   kind;
    data_t   push_data;
    data_t   back_data;
    data_t   front_data;

    assign kind      = req.payload.kind;
    assign push_data = DATA_WIDTH'(req.payload.push_value);
    assign full      = (cnt_reg == FULL_COUNT);
    assign empty     = (cnt_reg == '0);

    // Capture into the response register whenever it is free or being drained.
    assign advance   = pend_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !pend_reg || !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Build the cell chain
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_link_t left_link;
            cell_link_t right_link;

            if (gi == 0)
            begin : g_first
                // the front cell sees a phantom full neighbor carrying the push value
                assign left_link.valid = 1'b1;
                assign left_link.data  = push_data;
            end
            else
            begin : g_mid_left
                assign left_link = cell_state[gi-1];
            end

            if (gi == DEPTH-1)
            begin : g_last
                assign right_link.valid = 1'b0;
                assign right_link.data  = '0;
            end
            else
            begin : g_mid_right
                assign right_link = cell_state[gi+1];
            end

            dq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .left    (left_link),
                .right   (right_link),
                .state   (cell_state[gi]),
                .is_back (cell_back[gi])
            );
        end
    endgenerate

    // Select the back entry: exactly one cell flags itself as the back when not empty.
    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_back[i])
            begin
                back_data = back_data | cell_state[i].data;
            end
        end
    end

    assign front_data = cell_state[0].valid ? cell_state[0].data : '0;

    // Decode the operation into a chain command, popped value and status.
    always_comb
    begin
        ctl.cmd          = CELL_HOLD;
        ctl.data         = push_data;
        cnt_next         = cnt_reg;
        pend_popped_next = pend_popped_reg;
        pend_status_next = pend_status_reg;
        if (accept)
        begin
            pend_popped_next = '0;
            pend_status_next = STATUS_OK;
            case (kind)
                KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        pend_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ctl.cmd  = CELL_SHIFT_BACK;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        pend_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ctl.cmd  = CELL_PUSH_BACK;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (empty)
                    begin
                        pend_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        ctl.cmd          = CELL_SHIFT_FRONT;
                        pend_popped_next = front_data;
                        cnt_next         = cnt_reg - 1'b1;
                    end
                end
                KIND_POP_BACK:
                begin
                    if (empty)
                    begin
                        pend_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        ctl.cmd          = CELL_POP_BACK;
                        pend_popped_next = back_data;
                        cnt_next         = cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pending and response valid flags
    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (advance)
        begin
            pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold pending data, then capture the post-operation view of the chain.
    always_ff @(posedge clk)
    begin
        pend_popped_reg <= pend_popped_next;
        pend_status_reg <= pend_status_next;
        if (advance)
        begin
            out_reg.popped_value <= 32'(pend_popped_reg);
            out_reg.status       <= pend_status_reg;
            out_reg.front_value  <= 32'(front_data);
            out_reg.back_value   <= 32'(back_data);
            out_reg.entry_count  <= cnt_reg;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule
`default_nettype wire

// ===== sv/dq_checker.sv =====
// Checker: port-level properties of the double-ended queue, bound to the top level.
`default_nettype none
module dq_checker
    import dq_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         rsp_valid,
    input wire logic         rsp_ready,
    input wire rsp_payload_t rsp_payload
);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_payload.entry_count <= FULL_COUNT))
        else $error("entry count exceeds depth");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_payload.status == STATUS_EMPTY) |->
            (rsp_payload.entry_count == '0 && rsp_payload.popped_value == '0))
        else $error("empty status with entries held or value popped");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_payload.status == STATUS_FULL) |->
            (rsp_payload.entry_count == FULL_COUNT && rsp_payload.popped_value == '0))
        else $error("full status on a queue that is not full");

    a_empty_peek: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_payload.entry_count == '0) |->
            (rsp_payload.front_value == '0 && rsp_payload.back_value == '0))
        else $error("nonzero peek on an empty queue");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
        else $error("stalled response changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
`default_nettype wire
